/* rtl/brk_pkg.sv */
// Shared types and constants for the bracket packet receiver.
// No dependencies; every other file of the block but brk_ram imports this package.
package brk_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 7;
    localparam int CMD_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd91;
    localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd93;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHAR = 1'b0,
        CFG_END_CHAR   = 1'b1
    } t_cfg_idx;

    // Result fields known at transfer time; data comes later from the store
    typedef struct packed {
        logic             ready_res;
        logic             frame_done;
        logic [LEN_W-1:0] packet_length;
        logic             data_zero;
    } t_res_info;

endpackage

/* rtl/brk_in_if.sv */
// Input channel: valid/ready handshake with command, received byte and read index.
// Depends on brk_pkg for field widths.
interface brk_in_if import brk_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, output command, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input read_index,
                    output ready);
endinterface

/* rtl/brk_out_if.sv */
// Result channel: valid/ready handshake with flag, length and data fields.
// Depends on brk_pkg for field widths.
interface brk_out_if import brk_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ready_res;
    logic              frame_done;
    logic [LEN_W-1:0]  packet_length;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output ready_res, output frame_done,
                    output packet_length, output data_byte, input ready);
    modport sink   (input valid, input ready_res, input frame_done,
                    input packet_length, input data_byte, output ready);
endinterface

/* rtl/brk_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module brk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/brk_ctrl.sv */
// Framer control: configuration registers, frame state, bank select and
// store addressing. Depends on brk_pkg and brk_in_if.
module brk_ctrl import brk_pkg::*; #(
    parameter int BUF_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [BYTE_W-1:0]              i_cfg_data,
    brk_in_if.sink                         rx_ch,
    input  logic                           i_hold,
    output logic                           o_push,
    output t_res_info                      o_info,
    output logic                           o_we,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_waddr,
    output logic [BYTE_W-1:0]              o_wdata,
    output logic                           o_re,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_raddr
);

    localparam int CW = $clog2(BUF_DEPTH);
    localparam int AW = $clog2(2*BUF_DEPTH);
    localparam int LW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [AW-1:0] BANK1_BASE = AW'(BUF_DEPTH);
    localparam logic [CW-1:0] FILL_MAX   = CW'(BUF_DEPTH - 1);

    logic [BYTE_W-1:0] r_start_char, r_end_char;
    logic              r_in_frame, n_in_frame;
    logic [CW-1:0]     r_fill, n_fill;
    logic              r_bank, n_bank;
    logic [CW-1:0]     r_pub_len, n_pub_len;
    logic              r_ready_flag, n_ready_flag;

    t_cmd              cmd;
    logic              accept;
    logic              done;
    logic              wr_byte;
    logic              rd_hit;
    logic [LW-1:0]     len_ext;
    logic [AW-1:0]     fill_addr, idx_addr;

    assign cmd    = t_cmd'(rx_ch.command);
    assign rx_ch.ready = !i_hold;
    assign accept = rx_ch.valid && !i_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RST;
            r_end_char   <= END_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_CHAR: r_start_char <= i_cfg_data;
                CFG_END_CHAR:   r_end_char   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_in_frame   = r_in_frame;
        n_fill       = r_fill;
        n_bank       = r_bank;
        n_pub_len    = r_pub_len;
        n_ready_flag = r_ready_flag;
        done         = 1'b0;
        wr_byte      = 1'b0;
        unique case (cmd)
            CMD_BYTE: begin
                if (rx_ch.rx_byte == r_start_char) begin
                    // ignore a start byte while a packet waits for the host
                    if (!r_ready_flag) begin
                        n_in_frame = 1'b1;
                        n_fill     = '0;
                    end
                end else if (r_in_frame) begin
                    if (rx_ch.rx_byte == r_end_char) begin
                        n_bank       = !r_bank;
                        n_pub_len    = r_fill;
                        n_ready_flag = 1'b1;
                        n_in_frame   = 1'b0;
                        n_fill       = '0;
                        done         = 1'b1;
                    end else if (r_fill < FILL_MAX) begin
                        wr_byte = 1'b1;
                        n_fill  = r_fill + CW'(1);
                    end else begin
                        // overflow: drop the frame
                        n_in_frame = 1'b0;
                        n_fill     = '0;
                    end
                end
            end
            CMD_FETCH: n_ready_flag = 1'b0;
            CMD_READ:  ;
            CMD_NOP:   ;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_fill       <= '0;
            r_bank       <= 1'b0;
            r_pub_len    <= '0;
            r_ready_flag <= 1'b0;
        end else if (accept) begin
            r_in_frame   <= n_in_frame;
            r_fill       <= n_fill;
            r_bank       <= n_bank;
            r_pub_len    <= n_pub_len;
            r_ready_flag <= n_ready_flag;
        end
    end

    // Bytes go into the bank that the host is not reading
    assign fill_addr = AW'(r_fill);
    // A hit implies index below the length, so the index fits one bank
    assign idx_addr  = AW'(rx_ch.read_index);
    assign rd_hit    = (cmd == CMD_READ) && (LW'(rx_ch.read_index) < LW'(r_pub_len));
    assign len_ext   = LW'(n_pub_len);

    assign o_we    = accept && wr_byte;
    assign o_waddr = r_bank ? fill_addr : (fill_addr + BANK1_BASE);
    assign o_wdata = rx_ch.rx_byte;
    assign o_re    = accept && rd_hit;
    assign o_raddr = r_bank ? (idx_addr + BANK1_BASE) : idx_addr;

    assign o_push = accept;
    assign o_info.ready_res     = (cmd == CMD_BYTE) ? n_ready_flag : r_ready_flag;
    assign o_info.frame_done    = done;
    assign o_info.packet_length = len_ext[LEN_W-1:0];
    assign o_info.data_zero     = !rd_hit;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond capacity");

    a_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_fill == '0))
        else $error("fill count held outside a frame");

    a_swap_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && done) |=> (r_ready_flag && (r_bank != $past(r_bank))))
        else $error("frame end did not swap banks and raise the flag");

    a_no_write_when_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("store written and read by one transfer");

endmodule

/* rtl/brk_out.sv */
// Result path: stage that waits for store read data, then output register
// with a skid register. Depends on brk_pkg and brk_out_if.
module brk_out import brk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_res_info         i_info,
    input  logic [BYTE_W-1:0] i_rdata,
    output logic              o_hold,
    brk_out_if.source         res_ch
);

    typedef struct packed {
        logic              ready_res;
        logic              frame_done;
        logic [LEN_W-1:0]  packet_length;
        logic [BYTE_W-1:0] data_byte;
    } t_result;

    logic      r_s1_valid, n_s1_valid;
    t_res_info r_s1_info;
    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_result   r_out, r_skid;
    t_result   s1_res;
    logic      advance;
    logic      out_take;

    assign s1_res = '{ready_res:     r_s1_info.ready_res,
                      frame_done:    r_s1_info.frame_done,
                      packet_length: r_s1_info.packet_length,
                      data_byte:     r_s1_info.data_zero ? '0 : i_rdata};

    assign advance  = r_s1_valid && !r_skid_valid;
    assign out_take = r_out_valid && res_ch.ready;
    assign o_hold   = r_skid_valid;

    always_comb begin
        n_s1_valid   = i_push ? 1'b1 : (advance ? 1'b0 : r_s1_valid);
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_take) begin
            n_out_valid  = r_skid_valid || advance;
            n_skid_valid = 1'b0;
        end else if (advance) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_info <= i_info;
        end
        if (!r_out_valid || out_take) begin
            // refill from the skid first, it holds the older result
            r_out <= r_skid_valid ? r_skid : s1_res;
        end else if (advance) begin
            r_skid <= s1_res;
        end
    end

    assign res_ch.valid         = r_out_valid;
    assign res_ch.ready_res     = r_out.ready_res;
    assign res_ch.frame_done    = r_out.frame_done;
    assign res_ch.packet_length = r_out.packet_length;
    assign res_ch.data_byte     = r_out.data_byte;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full with output register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!r_skid_valid && (!r_s1_valid || advance)))
        else $error("transfer taken with no room in the result path");

    a_done_has_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> r_out.ready_res)
        else $error("frame end reported without ready flag");

endmodule

/* rtl/bracket_packet_receiver.sv */
// A result passes the store read stage, then the output register; the skid register
// holds it while the output register waits. Throughput: one item per cycle while the
// skid register is empty; the two-bank byte store takes one write or one read a cycle.
// Input ready depends only on the skid register, not on the result channel's ready.
// Reset (synchronous, active low) clears frame state, flags, lengths and the result path,
// and loads the start and end bytes; the byte store is not cleared and needs no clearing pass.
module bracket_packet_receiver import brk_pkg::*; #(
    parameter int BUF_DEPTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    brk_in_if.sink               i_rx_ch,
    brk_out_if.source            o_res_ch
);

    localparam int AW = $clog2(2*BUF_DEPTH);

    logic              hold;
    logic              push;
    t_res_info         info;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [BYTE_W-1:0] wdata, rdata;

    brk_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .rx_ch      (i_rx_ch),
        .i_hold     (hold),
        .o_push     (push),
        .o_info     (info),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr)
    );

    brk_ram #(.WIDTH(BYTE_W), .DEPTH(2*BUF_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    brk_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_info  (info),
        .i_rdata (rdata),
        .o_hold  (hold),
        .res_ch  (o_res_ch)
    );

endmodule

/* sim/bracket_packet_receiver_tb.sv */
// Self-checking testbench for bracket_packet_receiver: framed byte traffic and host requests.
// Depends on brk_pkg, brk_in_if, brk_out_if and the top level; scores every result in order.
`timescale 1ns / 100ps

module bracket_packet_receiver_tb;
    import brk_pkg::*;

    localparam int BUF_DEPTH   = 128;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_cmd              cmd;
        logic [BYTE_W-1:0] rx;
        logic [IDX_W-1:0]  idx;
    } t_host_item;

    typedef struct {
        logic              ready_res;
        logic              frame_done;
        logic [LEN_W-1:0]  packet_length;
        logic [BYTE_W-1:0] data_byte;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0] i_cfg_data;

    brk_in_if  rx_ch ();
    brk_out_if res_ch ();

    bracket_packet_receiver #(.BUF_DEPTH(BUF_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_ch    (rx_ch),
        .o_res_ch   (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // Host traffic waiting to be driven, and replies owed by the block
    t_host_item host_q[$];
    t_reply     reply_q[$];
    int         gen_count = 0;
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    int         src_gap = 0;
    int         snk_gap = 0;
    bit         src_idle_on = 1'b1;
    bit         snk_idle_on = 1'b1;

    // Shadow of the framer state
    logic [BYTE_W-1:0] sh_start;
    logic [BYTE_W-1:0] sh_end;
    bit                sh_in_frame;
    int                sh_fill;
    bit                sh_bank;
    logic [LEN_W-1:0]  sh_pub_len;
    bit                sh_ready;
    logic [BYTE_W-1:0] sh_store [0:2*BUF_DEPTH-1];

    function automatic t_reply framer_step(t_cmd c, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] ix);
        t_reply r;
        r.frame_done = 1'b0;
        r.data_byte  = '0;
        case (c)
            CMD_BYTE: begin
                if (b == sh_start) begin
                    // a pending packet blocks any new frame
                    if (!sh_ready) begin
                        sh_in_frame = 1'b1;
                        sh_fill = 0;
                    end
                end else if (sh_in_frame) begin
                    if (b == sh_end) begin
                        sh_bank = ~sh_bank;
                        sh_pub_len = LEN_W'(sh_fill);
                        sh_ready = 1'b1;
                        sh_in_frame = 1'b0;
                        sh_fill = 0;
                        r.frame_done = 1'b1;
                    end else if (sh_fill < BUF_DEPTH - 1) begin
                        sh_store[(sh_bank ? 0 : BUF_DEPTH) + sh_fill] = b;
                        sh_fill++;
                    end else begin
                        // overflow: drop the frame silently
                        sh_in_frame = 1'b0;
                        sh_fill = 0;
                    end
                end
                r.ready_res = sh_ready;
            end
            CMD_FETCH: begin
                r.ready_res = sh_ready;
                sh_ready = 1'b0;
            end
            CMD_READ: begin
                if (ix < sh_pub_len)
                    r.data_byte = sh_store[(sh_bank ? BUF_DEPTH : 0) + ix];
                r.ready_res = sh_ready;
            end
            default: r.ready_res = sh_ready;
        endcase
        r.packet_length = sh_pub_len;
        return r;
    endfunction

    // Unused fields get random content
    task automatic add_item(t_cmd c, int b, int ix);
        t_host_item it;
        it.cmd = c;
        it.rx  = (c == CMD_BYTE) ? BYTE_W'(b) : BYTE_W'($urandom_range(0, 255));
        it.idx = (c == CMD_READ) ? IDX_W'(ix) : IDX_W'($urandom_range(0, 127));
        host_q.push_back(it);
        gen_count++;
    endtask

    task automatic add_frame(int plen, bit noisy);
        int k;
        int b;
        if (!noisy || $urandom_range(0, 3) != 0)
            add_item(CMD_FETCH, 0, 0);
        add_item(CMD_BYTE, sh_start, 0);
        for (k = 0; k < plen; k++) begin
            if (noisy && $urandom_range(0, 49) == 0)
                add_item(CMD_BYTE, sh_start, 0);
            if (noisy && $urandom_range(0, 9) == 0)
                add_item(t_cmd'($urandom_range(1, 3)), 0, $urandom_range(0, 127));
            do b = $urandom_range(0, 255); while (b == sh_start || b == sh_end);
            add_item(CMD_BYTE, b, 0);
        end
        add_item(CMD_BYTE, sh_end, 0);
    endtask

    task automatic add_traffic(int n_items);
        int stop_at;
        int plen;
        int hi;
        int k;
        int n;
        int sel;
        stop_at = gen_count + n_items;
        while (gen_count < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                plen = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 130)
                                                    : $urandom_range(0, 12);
                add_frame(plen, 1'b1);
                hi = (plen + 1 > 127) ? 127 : plen + 1;
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    add_item(CMD_READ, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                      : $urandom_range(0, hi));
            end else begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    sel = $urandom_range(0, 3);
                    add_item(t_cmd'($urandom_range(0, 3)),
                             (sel == 0) ? sh_start : (sel == 1) ? sh_end : $urandom_range(0, 255),
                             $urandom_range(0, 127));
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (host_q.size() != 0 || rx_ch.valid || reply_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_cfg(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_CHAR;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_END_CHAR;
        i_cfg_data <= e;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_start = s;
        sh_end   = e;
        @(negedge i_clk);
    endtask

    // Driver: offer queued items, predict on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else begin
            if (rx_ch.valid && rx_ch.ready)
                reply_q.push_back(framer_step(t_cmd'(rx_ch.command), rx_ch.rx_byte,
                                              rx_ch.read_index));
            if (!rx_ch.valid || rx_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    rx_ch.valid <= 1'b0;
                end else if (host_q.size() > 0) begin
                    rx_ch.valid      <= 1'b1;
                    rx_ch.command    <= host_q[0].cmd;
                    rx_ch.rx_byte    <= host_q[0].rx;
                    rx_ch.read_index <= host_q[0].idx;
                    host_q.pop_front();
                    if (src_idle_on && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 6);
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: score each result transfer against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (reply_q.size() == 0) begin
                    $error("result with no prediction pending");
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    if (res_ch.ready_res !== want.ready_res) begin
                        $error("ready_res: expected %0d, actual %0d", want.ready_res,
                               res_ch.ready_res);
                        err_cnt++;
                    end
                    if (res_ch.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0d, actual %0d", want.frame_done,
                               res_ch.frame_done);
                        err_cnt++;
                    end
                    if (res_ch.packet_length !== want.packet_length) begin
                        $error("packet_length: expected %0d, actual %0d", want.packet_length,
                               res_ch.packet_length);
                        err_cnt++;
                    end
                    if (res_ch.data_byte !== want.data_byte) begin
                        $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte,
                               res_ch.data_byte);
                        err_cnt++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (snk_idle_on && $urandom_range(0, 4) == 0)
                    snk_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL bracket_packet_receiver");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_START_CHAR;
        i_cfg_data       = '0;
        rx_ch.valid      = 1'b0;
        rx_ch.command    = CMD_NOP;
        rx_ch.rx_byte    = '0;
        rx_ch.read_index = '0;
        res_ch.ready     = 1'b0;
        sh_start    = START_CHAR_RST;
        sh_end      = END_CHAR_RST;
        sh_in_frame = 1'b0;
        sh_fill     = 0;
        sh_bank     = 1'b0;
        sh_pub_len  = '0;
        sh_ready    = 1'b0;
        for (int i = 0; i < 2 * BUF_DEPTH; i++)
            sh_store[i] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset delimiters
        add_item(CMD_READ, 0, 0);
        add_item(CMD_READ, 0, 127);
        add_item(CMD_FETCH, 0, 0);
        add_item(CMD_NOP, 0, 0);
        add_item(CMD_BYTE, 8'h41, 0);          // outside a frame
        add_item(CMD_BYTE, sh_end, 0);         // end with no frame open
        add_item(CMD_BYTE, sh_start, 0);
        add_item(CMD_BYTE, 8'h00, 0);
        add_item(CMD_BYTE, 8'hFF, 0);
        add_item(CMD_BYTE, sh_end, 0);
        add_item(CMD_BYTE, sh_start, 0);       // packet pending: ignored
        add_item(CMD_BYTE, 8'h11, 0);
        add_item(CMD_READ, 0, 0);
        add_item(CMD_READ, 0, 1);
        add_item(CMD_READ, 0, 2);              // at length
        add_item(CMD_FETCH, 0, 0);
        add_item(CMD_FETCH, 0, 0);
        add_item(CMD_BYTE, sh_start, 0);
        add_item(CMD_BYTE, 8'h22, 0);
        add_item(CMD_BYTE, sh_start, 0);       // restart inside the frame
        add_item(CMD_BYTE, 8'h33, 0);
        add_item(CMD_BYTE, sh_end, 0);
        add_item(CMD_READ, 0, 0);
        add_item(CMD_FETCH, 0, 0);
        add_item(CMD_BYTE, sh_start, 0);
        add_item(CMD_BYTE, sh_end, 0);         // empty packet
        add_item(CMD_READ, 0, 0);
        add_traffic(230);

        // Hold the sender until every result is back, then change delimiters
        wait_drained();
        write_cfg(8'h00, 8'hFF);
        add_frame(127, 1'b0);                  // largest packet that fits
        add_item(CMD_READ, 0, 0);
        add_item(CMD_READ, 0, 126);
        add_item(CMD_READ, 0, 127);
        add_frame(128, 1'b0);                  // one byte too many: dropped
        add_item(CMD_READ, 0, 126);
        add_traffic(150);

        wait_drained();
        write_cfg(8'hFF, 8'h00);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        add_traffic(120);

        // Start and end equal: the byte always acts as a start
        wait_drained();
        write_cfg(8'h5A, 8'h5A);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        add_item(CMD_FETCH, 0, 0);
        add_item(CMD_BYTE, 8'h5A, 0);
        add_item(CMD_BYTE, 8'h01, 0);
        add_item(CMD_BYTE, 8'h5A, 0);
        add_item(CMD_READ, 0, 0);
        add_traffic(80);

        wait_drained();
        write_cfg(8'($urandom_range(1, 127)), 8'($urandom_range(128, 254)));
        add_traffic(150);

        // Last stretch runs without idling
        wait_drained();
        write_cfg(START_CHAR_RST, END_CHAR_RST);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        add_traffic(150);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (reply_q.size() != 0) begin
            $error("%0d predicted results never arrived", reply_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("PASS bracket_packet_receiver");
        else
            $display("FAIL bracket_packet_receiver");
        $finish;
    end

endmodule

/* files.f */
rtl/brk_pkg.sv
rtl/brk_in_if.sv
rtl/brk_out_if.sv
rtl/brk_ram.sv
rtl/brk_ctrl.sv
rtl/brk_out.sv
rtl/bracket_packet_receiver.sv
sim/bracket_packet_receiver_tb.sv
